>>> rtl/core/token_bucket_rate_limiter_defines.svh
// ---------------------------------------------------------------------------
// Token bucket rate limiter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define TBRL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbrl assertion failed");

// next-cycle implication
`define TBRL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbrl assertion failed");

`endif

>>> rtl/core/tbrl_pkg.sv
// ---------------------------------------------------------------------------
// Token bucket rate limiter package
// Field widths, register indexes, request modes, reset values, controller
// states and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tbrl_pkg;

  localparam int IO_TIME_W = 48;
  localparam int PERMIT_W  = 32;
  localparam int IV_W      = 32;
  localparam int TALLY_W   = 33;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;
  localparam int Q_W       = 35;
  localparam int PROD_W    = 2 * IV_W;

  localparam logic [Q_W-1:0] REFILL_CAP = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERMITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_US    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_TRY     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BURST   = 2'd2;

  localparam logic [IV_W-1:0]     RST_INTERVAL    = 32'd4096000;
  localparam logic [PERMIT_W-1:0] RST_MAX_PERMITS = 32'd1000;
  localparam logic [CFG_W-1:0]    RST_BURST_US    = 48'd1000000;
  localparam logic [PERMIT_W-1:0] RST_MAX_BURST   = 32'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_REFILL,
    S_WAIT,
    S_MUL,
    S_DECIDE,
    S_TAKE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic fast;
    logic div_start;
    logic div_step;
    logic refill;
    logic calc_wait;
    logic mul;
    logic decide;
    logic take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fast_ok;
    logic need_refill;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/tbrl_ctrl.sv
// ---------------------------------------------------------------------------
// Token bucket rate limiter controller
// Sequences one item through fast check, refill division, wait, debt
// multiply, decision and permit take, then hands the result to the output.
// ---------------------------------------------------------------------------
`include "token_bucket_rate_limiter_defines.svh"

module tbrl_ctrl
  import tbrl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (sts.fast_ok) begin
          cmd.fast  = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.need_refill) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        cmd.calc_wait = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_TAKE;
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `TBRL_ASSERT_IMP(a_out_load_free, cmd.out_load, sts.out_free)
  `TBRL_ASSERT_NXT(a_accept_eval, in_valid && in_ready, state_r == S_EVAL)

endmodule

>>> rtl/core/tbrl_dp.sv
// ---------------------------------------------------------------------------
// Token bucket rate limiter datapath
// Configuration and bucket state, bit-serial refill divider, debt multiplier,
// burst window accounting and the output register.
// ---------------------------------------------------------------------------
`include "token_bucket_rate_limiter_defines.svh"

module tbrl_dp
  import tbrl_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [IO_TIME_W-1:0] in_now_us,
  input  logic [PERMIT_W-1:0]  in_required_permits,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_granted,
  output logic [IO_TIME_W-1:0] out_wait_us,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int DIV_W = TIME_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int SUM_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

  // configuration
  logic [IV_W-1:0]     iv_r;
  logic [PERMIT_W-1:0] max_permits_r;
  logic [CFG_W-1:0]    burst_iv_r;
  logic [PERMIT_W-1:0] max_burst_r;

  // bucket state
  logic [PERMIT_W-1:0]  stored_r,   stored_nxt;
  logic [TIME_BITS-1:0] nft_r,      nft_nxt;
  logic [TALLY_W-1:0]   tally_r,    tally_nxt;
  logic [TIME_BITS-1:0] deadline_r, deadline_nxt;

  // current item
  logic [TIME_BITS-1:0] now_r;
  logic [PERMIT_W-1:0]  req_r;
  logic [MODE_W-1:0]    mode_r;

  // divider
  logic [DIV_W-1:0] dvd_r;
  logic [IV_W-1:0]  rem_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;

  logic [PROD_W-1:0]    prod_r;
  logic [TIME_BITS-1:0] wait_r;
  logic                 take_r;
  logic                 granted_r;

  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [IO_TIME_W-1:0] out_wait_r;

  logic [TIME_BITS-1:0] elapsed;
  logic [IV_W:0]        r_sh;
  logic [IV_W:0]        r_diff;
  logic                 div_ge;
  logic [IV_W-1:0]      rem_step;
  logic [Q_W:0]         q_sh;
  logic [Q_W-1:0]       q_step;
  logic [Q_W-1:0]       q_eff;
  logic [Q_W:0]         refill_sum;
  logic [PERMIT_W-1:0]  refilled;
  logic [TIME_BITS-1:0] wait_calc;
  logic [PERMIT_W-1:0]  deficit;
  logic [PROD_W-1:0]    debt;
  logic [SUM_W-1:0]     nft_sum;
  logic [TIME_BITS-1:0] nft_take;
  logic [SUM_W-1:0]     dl_sum;
  logic [TIME_BITS-1:0] dl_new;
  logic [TALLY_W:0]     tally_sum;
  logic                 burst_ok;
  logic                 wait_zero;
  logic                 burst_window;
  logic                 window_end;
  logic                 dec_take;
  logic                 dec_grant;
  logic                 short_take;

  assign elapsed  = now_r - nft_r;
  assign r_sh     = {rem_r, dvd_r[DIV_W-1]};
  assign r_diff   = r_sh - {1'b0, iv_r};
  assign div_ge   = (r_sh >= {1'b0, iv_r});
  assign rem_step = div_ge ? r_diff[IV_W-1:0] : r_sh[IV_W-1:0];
  assign q_sh     = {q_r, div_ge};
  assign q_step   = (q_sh > {1'b0, REFILL_CAP}) ? REFILL_CAP : q_sh[Q_W-1:0];

  assign q_eff      = (iv_r == '0) ? REFILL_CAP : q_r;
  assign refill_sum = (Q_W+1)'(stored_r) + (Q_W+1)'(q_eff);
  assign refilled   = (refill_sum < (Q_W+1)'(max_permits_r)) ?
                      refill_sum[PERMIT_W-1:0] : max_permits_r;

  assign wait_calc = (nft_r > now_r) ? (nft_r - now_r) : '0;
  assign deficit   = req_r - stored_r;
  assign debt      = prod_r >> FRAC_BITS;
  assign nft_sum   = SUM_W'(nft_r) + SUM_W'(debt);
  assign nft_take  = (nft_sum > SUM_W'(TIME_MASK)) ? TIME_MASK : nft_sum[TIME_BITS-1:0];
  assign dl_sum    = SUM_W'(now_r) + SUM_W'(burst_iv_r);
  assign dl_new    = (dl_sum > SUM_W'(TIME_MASK)) ? TIME_MASK : dl_sum[TIME_BITS-1:0];

  assign tally_sum    = (TALLY_W+1)'(tally_r) + (TALLY_W+1)'(req_r);
  assign burst_ok     = (tally_sum < (TALLY_W+1)'(max_burst_r)) && (nft_r < deadline_r);
  assign wait_zero    = (wait_r == '0);
  assign burst_window = (mode_r == MODE_BURST) && !wait_zero;
  assign window_end   = (now_r >= deadline_r);
  assign short_take   = (req_r > stored_r);

  always_comb begin
    unique case (mode_r)
      MODE_RESERVE: begin
        dec_take  = 1'b1;
        dec_grant = wait_zero;
      end
      MODE_BURST: begin
        dec_take  = wait_zero || burst_ok;
        dec_grant = wait_zero || burst_ok;
      end
      default: begin
        dec_take  = wait_zero;
        dec_grant = wait_zero;
      end
    endcase
  end

  always_comb begin
    stored_nxt   = stored_r;
    nft_nxt      = nft_r;
    tally_nxt    = tally_r;
    deadline_nxt = deadline_r;
    priority if (cmd.fast) begin
      stored_nxt = stored_r - req_r;
    end else if (cmd.refill) begin
      stored_nxt = refilled;
      nft_nxt    = now_r;
    end else if (cmd.take && take_r) begin
      if (short_take) begin
        stored_nxt = '0;
        nft_nxt    = nft_take;
      end else begin
        stored_nxt = stored_r - req_r;
      end
    end
    if (cmd.decide && burst_window) begin
      priority if (window_end) begin
        tally_nxt    = '0;
        deadline_nxt = dl_new;
      end else if (burst_ok) begin
        tally_nxt = tally_sum[TALLY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r          <= RST_INTERVAL;
      max_permits_r <= RST_MAX_PERMITS;
      burst_iv_r    <= RST_BURST_US;
      max_burst_r   <= RST_MAX_BURST;
      stored_r      <= '0;
      nft_r         <= '0;
      tally_r       <= '0;
      deadline_r    <= TIME_BITS'(RST_BURST_US);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INTERVAL:    iv_r          <= cfg_wdata[IV_W-1:0];
          REG_MAX_PERMITS: max_permits_r <= cfg_wdata[PERMIT_W-1:0];
          REG_BURST_US:    burst_iv_r    <= cfg_wdata;
          REG_MAX_BURST:   max_burst_r   <= cfg_wdata[PERMIT_W-1:0];
        endcase
      end
      stored_r   <= stored_nxt;
      nft_r      <= nft_nxt;
      tally_r    <= tally_nxt;
      deadline_r <= deadline_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= TIME_BITS'(in_now_us);
      req_r  <= in_required_permits;
      mode_r <= in_mode;
    end
    if (cmd.div_start) begin
      dvd_r <= DIV_W'(elapsed) << FRAC_BITS;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= CNT_W'(DIV_W);
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_step;
      q_r   <= q_step;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(deficit) * PROD_W'(iv_r);
    end
    if (cmd.fast) begin
      granted_r <= 1'b1;
      wait_r    <= '0;
    end else if (cmd.calc_wait) begin
      wait_r <= wait_calc;
    end else if (cmd.decide) begin
      granted_r <= dec_grant;
      take_r    <= dec_take;
    end
    if (cmd.out_load) begin
      out_granted_r <= granted_r;
      out_wait_r    <= IO_TIME_W'(wait_r);
    end
  end

  assign sts.fast_ok     = (stored_r > req_r);
  assign sts.need_refill = (now_r > nft_r);
  assign sts.div_last    = (cnt_r == CNT_W'(1));
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_wait_us = out_wait_r;

  `TBRL_ASSERT_NXT(a_fast_result, cmd.fast, granted_r && (wait_r == '0))
  `TBRL_ASSERT_NXT(a_refill_cap, cmd.refill, stored_r <= $past(max_permits_r))
  `TBRL_ASSERT_NXT(a_wait_zero, cmd.calc_wait && (now_r >= nft_r), wait_r == '0)

endmodule

>>> rtl/core/token_bucket_rate_limiter.sv
// ---------------------------------------------------------------------------
// Token bucket rate limiter
// Smooth-refill token bucket with try, reserve and burst request modes.
// ---------------------------------------------------------------------------
// One item is in flight at a time. A request served from stored permits
// goes from the evaluate state straight to the output state and into the
// output register, and then the next item is taken. A rate-limited request
// with no time elapsed since the next free time passes through the wait,
// multiply, decide and take states before the output state, and one that
// refills first runs the divider and the refill state. The refill count
// comes from a restoring divider that retires one quotient bit per cycle
// over the elapsed time shifted by FRAC_BITS. A new item is taken while the
// previous result still waits in the output register; a result held there
// blocks the next one from leaving the controller. Configuration writes
// take effect at once and belong in idle time.
module token_bucket_rate_limiter
  import tbrl_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IO_TIME_W-1:0] in_now_us,
  input  logic [PERMIT_W-1:0]  in_required_permits,
  input  logic [MODE_W-1:0]    in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_granted,
  output logic [IO_TIME_W-1:0] out_wait_us
);

  cmd_t cmd;
  sts_t sts;

  tbrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbrl_dp #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_now_us           (in_now_us),
    .in_required_permits (in_required_permits),
    .in_mode             (in_mode),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_wait_us         (out_wait_us),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
